[hdl/mqpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqpd_pkg
// Shared types and constants for the MQTT publish deframer.
// ----------------------------------------------------------------------------
package mqpd_pkg;

    // widths of the stream and of the length bookkeeping
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 28;
    localparam int GROUP_W  = 2;
    localparam int TOPIC_W  = 16;

    // most length bytes allowed in the remaining length field
    localparam int LEN_BYTES = 4;

    // remaining length field coding and reset value of the accepted header
    localparam logic [BYTE_W-1:0] GROUP_MASK   = 8'h7F;
    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h30;

    // result kinds
    localparam logic [1:0] KIND_TOPIC   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_LEN_LONG  = 2'd1;
    localparam logic [1:0] ERR_TOPIC_LEN = 2'd2;

    // parse phase
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LEN     = 3'd1,
        PH_SKIP    = 3'd2,
        PH_THI     = 3'd3,
        PH_TLO     = 3'd4,
        PH_TOPIC   = 3'd5,
        PH_PAYLOAD = 3'd6
    } phase_t;

    // one result item
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic [1:0]        kind;
        logic [1:0]        err;
        logic              last;
    } result_t;

endpackage

[hdl/mqpd_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqpd_parser
// Packet state machine: takes one stream byte per accepted item, updates the
// parse state and gives at most one result item in the same cycle.
// ----------------------------------------------------------------------------
module mqpd_parser
    import mqpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [BYTE_W-1:0] cfg_wr_data,
    input  logic              accept,
    input  logic [BYTE_W-1:0] data_byte,
    output result_t           result
);

    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  remaining_reg, remaining_next;
    logic [GROUP_W-1:0]  group_reg, group_next;
    logic [TOPIC_W-1:0]  topic_reg, topic_next;
    logic                deliver_reg, deliver_next;
    logic [BYTE_W-1:0]   header_reg;

    logic [COUNT_W-1:0]  group_add;
    logic [COUNT_W-1:0]  rem_sum;
    logic [COUNT_W-1:0]  rem_dec;
    logic [TOPIC_W-1:0]  topic_full;
    logic [GROUP_W:0]    group_inc;

    // accepted header register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
        end
        else if (cfg_wr_en)
        begin
            header_reg <= cfg_wr_data;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            remaining_reg <= '0;
            group_reg     <= '0;
            topic_reg     <= '0;
            deliver_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            group_reg     <= group_next;
            topic_reg     <= topic_next;
            deliver_reg   <= deliver_next;
        end
    end

    // 7-bit length group placed at its weight
    always_comb
    begin
        case (group_reg)
            2'd0:    group_add = {{(COUNT_W-7){1'b0}}, data_byte[6:0]};
            2'd1:    group_add = {{(COUNT_W-14){1'b0}}, data_byte[6:0], 7'd0};
            2'd2:    group_add = {{(COUNT_W-21){1'b0}}, data_byte[6:0], 14'd0};
            default: group_add = {data_byte[6:0], 21'd0};
        endcase
    end

    assign rem_sum    = remaining_reg + group_add;
    assign rem_dec    = remaining_reg - COUNT_W'(1);
    assign topic_full = {topic_reg[TOPIC_W-1:BYTE_W], data_byte};
    assign group_inc  = {1'b0, group_reg} + (GROUP_W+1)'(1);

    // next state and result
    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        group_next     = group_reg;
        topic_next     = topic_reg;
        deliver_next   = deliver_reg;
        result         = '0;

        case (phase_reg)
            PH_LEN:
            begin
                remaining_next = rem_sum;
                if (data_byte[BYTE_W-1])
                begin
                    if (group_inc >= (GROUP_W+1)'(LEN_BYTES))
                    begin
                        phase_next   = PH_HEADER;
                        result.valid = 1'b1;
                        result.kind  = KIND_ERROR;
                        result.err   = ERR_LEN_LONG;
                    end
                    else
                    begin
                        group_next = group_inc[GROUP_W-1:0];
                    end
                end
                else if (rem_sum == '0)
                begin
                    phase_next = PH_HEADER;
                end
                else
                begin
                    phase_next = deliver_reg ? PH_THI : PH_SKIP;
                end
            end

            PH_SKIP:
            begin
                remaining_next = rem_dec;
                if (rem_dec == '0)
                begin
                    phase_next = PH_HEADER;
                end
            end

            PH_THI:
            begin
                topic_next     = {data_byte, {BYTE_W{1'b0}}};
                remaining_next = rem_dec;
                if (rem_dec == '0)
                begin
                    phase_next   = PH_HEADER;
                    result.valid = 1'b1;
                    result.kind  = KIND_ERROR;
                    result.err   = ERR_TOPIC_LEN;
                end
                else
                begin
                    phase_next = PH_TLO;
                end
            end

            PH_TLO:
            begin
                topic_next     = topic_full;
                remaining_next = rem_dec;
                if ({{(COUNT_W-TOPIC_W){1'b0}}, topic_full} > rem_dec)
                begin
                    phase_next   = (rem_dec == '0) ? PH_HEADER : PH_SKIP;
                    result.valid = 1'b1;
                    result.kind  = KIND_ERROR;
                    result.err   = ERR_TOPIC_LEN;
                end
                else if (rem_dec == '0)
                begin
                    phase_next = PH_HEADER;
                end
                else
                begin
                    phase_next = (topic_full == '0) ? PH_PAYLOAD : PH_TOPIC;
                end
            end

            PH_TOPIC:
            begin
                topic_next     = topic_reg - TOPIC_W'(1);
                remaining_next = rem_dec;
                result.valid   = 1'b1;
                result.data    = data_byte;
                result.kind    = KIND_TOPIC;
                if (rem_dec == '0)
                begin
                    phase_next  = PH_HEADER;
                    result.last = 1'b1;
                end
                else if (topic_next == '0)
                begin
                    phase_next = PH_PAYLOAD;
                end
            end

            PH_PAYLOAD:
            begin
                remaining_next = rem_dec;
                result.valid   = 1'b1;
                result.data    = data_byte;
                result.kind    = KIND_PAYLOAD;
                if (rem_dec == '0)
                begin
                    phase_next  = PH_HEADER;
                    result.last = 1'b1;
                end
            end

            // header byte, also any unused phase code
            default:
            begin
                deliver_next   = (data_byte == header_reg);
                remaining_next = '0;
                group_next     = '0;
                topic_next     = '0;
                phase_next     = PH_LEN;
            end
        endcase
    end

endmodule

[hdl/mqtt_publish_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqtt_publish_deframer
// Byte-serial deframer that delivers topic and payload bytes of MQTT
// packets whose first header byte matches a programmable value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one stream byte per item on data_byte, taken when
//   in_valid is high and in_stall is low. Output channel: one result item
//   (data_out, kind, error_code, last) taken when out_valid is high and
//   out_stall is low. Header, length and topic length bytes give no item;
//   topic and payload bytes give one each; faults give an error item.
//   Each result is registered in the output register, or in the skid
//   register while the receiver stalls. Throughput: one byte per cycle
//   while in_stall is low, set by the single parse state machine.
//   cfg_wr_en / cfg_wr_data write the accepted header byte; write only
//   while the block is idle.
//   Reset: parse state returns to expecting a header byte, the accepted
//   header returns to 0x30 and both result registers are emptied.
//   Receiver stall: the output register holds its item, one more result
//   goes into a skid register, and in_stall rises only once that skid
//   register is full, so no result is lost or repeated.
// ----------------------------------------------------------------------------
module mqtt_publish_deframer
    import mqpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [BYTE_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] data_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] data_out,
    output logic [1:0]        kind,
    output logic [1:0]        error_code,
    output logic              last
);

    result_t result;
    result_t out_reg;
    result_t skid_reg;
    logic    accept;
    logic    out_free;

    assign in_stall = skid_reg.valid;
    assign accept   = in_valid && !skid_reg.valid;
    assign out_free = !out_reg.valid || !out_stall;

    // per-byte parse logic
    mqpd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .data_byte   (data_byte),
        .result      (result)
    );

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg  <= '0;
            skid_reg <= '0;
        end
        else if (out_free)
        begin
            if (skid_reg.valid)
            begin
                out_reg        <= skid_reg;
                skid_reg.valid <= 1'b0;
            end
            else if (accept && result.valid)
            begin
                out_reg <= result;
            end
            else
            begin
                out_reg.valid <= 1'b0;
            end
        end
        else if (accept && result.valid)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid  = out_reg.valid;
    assign data_out   = out_reg.data;
    assign kind       = out_reg.kind;
    assign error_code = out_reg.err;
    assign last       = out_reg.last;

endmodule

[hdl/mqpd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqpd_checker
// Port-level checks for the MQTT publish deframer, bound to the top level.
// ----------------------------------------------------------------------------
module mqpd_checker
    import mqpd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [BYTE_W-1:0] data_out,
    input logic [1:0]        kind,
    input logic [1:0]        error_code,
    input logic              last
);

    // a stalled item stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output item dropped while stalled");

    // input is held back only while an output item is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // error items carry a code and no data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |->
            error_code != ERR_NONE && data_out == '0 && !last)
        else $error("malformed error item");

    // delivered bytes carry no error code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_ERROR |->
            error_code == ERR_NONE && (kind == KIND_TOPIC || kind == KIND_PAYLOAD))
        else $error("malformed data item");

endmodule

bind mqtt_publish_deframer mqpd_checker u_mqpd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_out   (data_out),
    .kind       (kind),
    .error_code (error_code),
    .last       (last)
);

[tb/tb_mqtt_publish_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mqtt_publish_deframer
// Self-checking bench for the MQTT publish deframer. A byte-level model of
// the parser predicts every topic, payload and error item from the bytes the
// block accepts. A scoreboard compares each delivered item field by field, in
// order. The stream starts with hand-built packets. Random packets follow:
// mostly well-formed ones, plus skipped packets, oversized length fields,
// oversized topics, truncated headers and empty packets. Both sides of the
// block idle at random, and one long receiver hold fills the output registers.
// The accepted header changes between groups of packets.
// ----------------------------------------------------------------------------
module tb_mqtt_publish_deframer;
    import mqpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_GROUPS     = 6;
    localparam int ITEMS_PER_GROUP = 250;

    // one delivered item as seen on the output channel
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [1:0]        kind;
        logic [1:0]        err;
        logic              last;
    } deframe_result_t;

    // parser model plus the queue of items it predicts
    class publish_byte_scoreboard;
        phase_t             parse_ph   = PH_HEADER;
        logic [COUNT_W-1:0] remaining  = '0;
        logic [GROUP_W-1:0] group      = '0;
        logic [TOPIC_W-1:0] topic_left = '0;
        logic               deliver    = 1'b0;
        logic [BYTE_W-1:0]  header     = HEADER_RESET;
        deframe_result_t    pending_results[$];
        int                 errors     = 0;

        function int pending();
            return pending_results.size();
        endfunction

        function void queue_result(logic [BYTE_W-1:0] d, logic [1:0] k, logic [1:0] e,
                                   logic l);
            deframe_result_t r;
            r.data = d;
            r.kind = k;
            r.err  = e;
            r.last = l;
            pending_results.push_back(r);
        endfunction

        // advance the parser by one accepted byte
        function void note_byte(logic [BYTE_W-1:0] b);
            logic [COUNT_W-1:0] grp_val;
            grp_val = COUNT_W'(b & GROUP_MASK);
            case (parse_ph)
                PH_LEN:
                begin
                    remaining = remaining + (grp_val << (7 * group));
                    if (b[7])
                    begin
                        // continuation on the last allowed group
                        if (group + 1 >= LEN_BYTES)
                        begin
                            parse_ph = PH_HEADER;
                            queue_result('0, KIND_ERROR, ERR_LEN_LONG, 1'b0);
                        end
                        else
                            group = group + 1'b1;
                    end
                    else if (remaining == 0)
                        parse_ph = PH_HEADER;
                    else
                        parse_ph = deliver ? PH_THI : PH_SKIP;
                end
                PH_SKIP:
                begin
                    remaining = remaining - 1'b1;
                    if (remaining == 0)
                        parse_ph = PH_HEADER;
                end
                PH_THI:
                begin
                    topic_left = {b, 8'h00};
                    remaining  = remaining - 1'b1;
                    // packet ends inside the topic length
                    if (remaining == 0)
                    begin
                        parse_ph = PH_HEADER;
                        queue_result('0, KIND_ERROR, ERR_TOPIC_LEN, 1'b0);
                    end
                    else
                        parse_ph = PH_TLO;
                end
                PH_TLO:
                begin
                    topic_left = topic_left | b;
                    remaining  = remaining - 1'b1;
                    if (topic_left > remaining)
                    begin
                        parse_ph = (remaining == 0) ? PH_HEADER : PH_SKIP;
                        queue_result('0, KIND_ERROR, ERR_TOPIC_LEN, 1'b0);
                    end
                    else if (remaining == 0)
                        parse_ph = PH_HEADER;
                    else
                        parse_ph = (topic_left == 0) ? PH_PAYLOAD : PH_TOPIC;
                end
                PH_TOPIC:
                begin
                    topic_left = topic_left - 1'b1;
                    remaining  = remaining - 1'b1;
                    if (remaining == 0)
                    begin
                        parse_ph = PH_HEADER;
                        queue_result(b, KIND_TOPIC, ERR_NONE, 1'b1);
                    end
                    else
                    begin
                        if (topic_left == 0)
                            parse_ph = PH_PAYLOAD;
                        queue_result(b, KIND_TOPIC, ERR_NONE, 1'b0);
                    end
                end
                PH_PAYLOAD:
                begin
                    remaining = remaining - 1'b1;
                    queue_result(b, KIND_PAYLOAD, ERR_NONE, remaining == 0);
                    if (remaining == 0)
                        parse_ph = PH_HEADER;
                end
                default:
                begin
                    // header byte, also any unused phase code
                    deliver    = (b == header);
                    remaining  = '0;
                    group      = '0;
                    topic_left = '0;
                    parse_ph   = PH_LEN;
                end
            endcase
        endfunction

        task report_mismatch(input string what);
            $display("%0t ns mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(input logic [BYTE_W-1:0] d, input logic [1:0] k,
                          input logic [1:0] e, input logic l);
            deframe_result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected item data=%h kind=%0d err=%0d last=%b",
                                          d, k, e, l));
                return;
            end
            want = pending_results.pop_front();
            if (d !== want.data)
                report_mismatch($sformatf("data_out %h, want %h", d, want.data));
            if (k !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", k, want.kind));
            if (e !== want.err)
                report_mismatch($sformatf("error_code %0d, want %0d", e, want.err));
            if (l !== want.last)
                report_mismatch($sformatf("last %b, want %b", l, want.last));
        endtask
    endclass

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [BYTE_W-1:0] cfg_wr_data = '0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] data_byte   = '0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic [BYTE_W-1:0] data_out;
    logic [1:0]        kind;
    logic [1:0]        error_code;
    logic              last;

    publish_byte_scoreboard sb = new();

    // stimulus knobs and counters, some of them shared with the receiver
    bit in_burst      = 1'b0;
    bit ignoring      = 1'b0;
    bit long_hold_req = 1'b0;
    int rx_stall_pct  = 25;
    int items_sent    = 0;
    int quiet_cycles  = 0;

    mqtt_publish_deframer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_out    (data_out),
        .kind        (kind),
        .error_code  (error_code),
        .last        (last)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // any header byte other than the accepted one
    function automatic logic [BYTE_W-1:0] pick_other(logic [BYTE_W-1:0] hdr);
        logic [BYTE_W-1:0] v;
        do
            v = rand_byte();
        while (v == hdr);
        return v;
    endfunction

    // mostly minimal length encoding, sometimes padded with zero groups
    function automatic int pick_groups();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(1, LEN_BYTES) : 1;
    endfunction

    // sender idle time: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (in_burst || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // offer one byte and wait until the block takes it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(b);
        if (!ignoring)
            items_sent++;
    endtask

    // remaining length, least significant group first
    task automatic send_length(input int value, input int groups);
        int v;
        int n;
        v = value;
        n = 1;
        while (v >= 128 || n < groups)
        begin
            send_byte({1'b1, v[6:0]});
            v = v / 128;
            n++;
        end
        send_byte({1'b0, v[6:0]});
    endtask

    // complete packet with a topic length and random topic and payload bytes
    task automatic send_packet(input logic [BYTE_W-1:0] hdr, input int tlen, input int plen);
        send_byte(hdr);
        ignoring = (hdr != sb.header);
        send_length(2 + tlen + plen, pick_groups());
        send_byte(tlen[15:8]);
        send_byte(tlen[7:0]);
        repeat (tlen + plen)
            send_byte(rand_byte());
        ignoring = 1'b0;
    endtask

    task automatic random_packet();
        int sel;
        int rem;
        int tlen;
        logic [BYTE_W-1:0] hdr;
        logic [BYTE_W-1:0] other;
        sel   = $urandom_range(0, 99);
        hdr   = sb.header;
        other = pick_other(hdr);
        if (sel < 50)
            send_packet(hdr, $urandom_range(0, 8), $urandom_range(0, 16));
        else if (sel < 62)
            send_packet(other, $urandom_range(0, 6), $urandom_range(0, 12));
        else if (sel < 63)
        begin
            // topic long enough to use the high length byte
            send_packet(hdr, $urandom_range(256, 300), $urandom_range(0, 60));
        end
        else if (sel < 70)
        begin
            // length field that never ends
            send_byte($urandom_range(0, 1) ? hdr : other);
            repeat (LEN_BYTES)
                send_byte(rand_byte() | 8'h80);
        end
        else if (sel < 78)
        begin
            // topic length beyond the packet end
            rem  = $urandom_range(2, 20);
            tlen = $urandom_range(rem - 1, 65535);
            send_byte(hdr);
            send_length(rem, pick_groups());
            send_byte(tlen[15:8]);
            send_byte(tlen[7:0]);
            repeat (rem - 2)
                send_byte(rand_byte());
        end
        else if (sel < 83)
        begin
            // packet cut inside the topic length
            send_byte(hdr);
            send_length(1, pick_groups());
            send_byte(rand_byte());
        end
        else if (sel < 88)
        begin
            // empty packet
            send_byte($urandom_range(0, 1) ? hdr : other);
            send_length(0, pick_groups());
        end
        else if (sel < 93)
            send_packet(hdr, 0, 0);
        else
            send_packet(hdr, 0, $urandom_range(1, 12));
    endtask

    // change the accepted header once the block has gone quiet
    task automatic write_header(input logic [BYTE_W-1:0] value);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.header = value;
    endtask

    // receiver: check each taken item, then pick the next stall
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(data_out, kind, error_code, last);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = 80;
            end
            else if (hold_left == 0 && $urandom_range(0, 499) == 0)
                hold_left = $urandom_range(20, 50);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        logic [BYTE_W-1:0] opening_seq [25];
        logic [BYTE_W-1:0] header_plan [NUM_GROUPS];
        bit                burst_plan  [NUM_GROUPS];
        int                stall_plan  [NUM_GROUPS];
        // topic and payload with last; empty; topic length only; cut topic
        // length; oversized topic; skipped packet with an endless length
        opening_seq = '{8'h30, 8'h04, 8'h00, 8'h01, 8'h00, 8'hFF,
                        8'h30, 8'h00,
                        8'h30, 8'h02, 8'h00, 8'h00,
                        8'h30, 8'h01, 8'hA5,
                        8'h30, 8'h03, 8'hFF, 8'hFE, 8'h5A,
                        8'hC5, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        header_plan = '{HEADER_RESET, 8'h00, 8'hFF, 8'h00, HEADER_RESET, 8'h00};
        header_plan[3] = rand_byte();
        header_plan[5] = rand_byte();
        burst_plan  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
        stall_plan  = '{25, 0, 50, 10, 70, 30};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening_seq[i])
            send_byte(opening_seq[i]);
        items_sent = 0;

        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            if (g > 0)
                write_header(header_plan[g]);
            in_burst     = burst_plan[g];
            rx_stall_pct = stall_plan[g];
            // back the output up while the sender keeps streaming
            if (g == 3)
                long_hold_req = 1'b1;
            while (items_sent < (g + 1) * ITEMS_PER_GROUP)
                random_packet();
        end

        // drain
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
